FILE: hw/rtl/sis_pkg.sv
// Package for the stable insertion sorter: types, widths and defaults.
package sis_pkg;

    localparam int unsigned SIS_DEPTH = 64;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned TAG_W     = 16;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Command broadcast to every cell at once.
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t data;
    } cmd_t;

endpackage

FILE: hw/rtl/sis_req_if.sv
// Request channel: insert or read beats into the sorter.
interface sis_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [sis_pkg::KEY_W-1:0] key;
    logic [sis_pkg::TAG_W-1:0] tag;

    modport source (output valid, output kind, output key, output tag, input ready);
    modport sink   (input valid, input kind, input key, input tag, output ready);
endinterface

FILE: hw/rtl/sis_rsp_if.sv
// Response channel: one beat per read request.
interface sis_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [sis_pkg::KEY_W-1:0] out_key;
    logic [sis_pkg::TAG_W-1:0] out_tag;
    logic                      valid_res;
    logic                      last;
    logic                      overflow;

    modport source (output valid, output out_key, output out_tag, output valid_res,
                    output last, output overflow, input ready);
    modport sink   (input valid, input out_key, input out_tag, input valid_res,
                    input last, input overflow, output ready);
endinterface

FILE: hw/rtl/sis_cell.sv
// One slot of the sorted chain: holds an entry, shifts up on insert, down on pop.
module sis_cell (
    input  logic            clk,
    input  sis_pkg::cmd_t   cmd,
    input  logic            occupied,
    input  logic            prev_place,
    input  sis_pkg::entry_t prev_entry,
    input  sis_pkg::entry_t next_entry,
    output sis_pkg::entry_t entry,
    output logic            place
);

    sis_pkg::entry_t entry_reg;
    sis_pkg::entry_t entry_next;

    // Strict compare keeps equal keys in arrival order.
    assign place = !occupied || (entry_reg.key > cmd.data.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.pop)
        begin
            entry_next = next_entry;
        end
        else if (cmd.ins)
        begin
            priority if (prev_place)
                entry_next = prev_entry;
            else if (place)
                entry_next = cmd.data;
            else
                entry_next = entry_reg;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hw/rtl/stable_insertion_sorter.sv
// Top level of the stable insertion sorter: chain of cells, count, result register.
//
//  channel | dir | beat payload                                  | produced
//  req     | in  | kind, key[31:0], tag[15:0]                    | every request
//  rsp     | out | out_key, out_tag, valid_res, last, overflow   | one per read
//
// One request per cycle while req.ready is high; every cell compares the broadcast
// key and shifts in the same cycle, so all DEPTH cells update together.
// A read result sits in one output register; req.ready drops only while that
// register is full and rsp.ready is low.
// Reset clears the entry count, the overflow flag and the output valid;
// cell contents are not reset and are never read before being written.
module stable_insertion_sorter #(
    parameter int unsigned DEPTH = sis_pkg::SIS_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    sis_req_if.sink   req,
    sis_rsp_if.source rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    sis_pkg::entry_t       rsp_entry_reg, rsp_entry_next;
    logic                  rsp_vres_reg, rsp_vres_next;
    logic                  rsp_last_reg, rsp_last_next;
    logic                  rsp_ovf_reg, rsp_ovf_next;

    logic                  req_fire;
    logic                  is_read;
    logic                  empty;
    logic                  full;
    sis_pkg::cmd_t         cmd;
    sis_pkg::entry_t       cell_entry [DEPTH];
    logic [DEPTH-1:0]      cell_place;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign is_read   = (sis_pkg::kind_t'(req.kind) == sis_pkg::KIND_READ);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    assign cmd.ins       = req_fire && !is_read && !full;
    assign cmd.pop       = req_fire && is_read && !empty;
    assign cmd.data.key  = req.key;
    assign cmd.data.tag  = req.tag;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic            occ;
        logic            pp;
        sis_pkg::entry_t pe;
        sis_pkg::entry_t ne;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign pp = 1'b0;
            assign pe = '0;
        end
        else
        begin : g_body
            assign pp = cell_place[i-1];
            assign pe = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign ne = '0;
        end
        else
        begin : g_inner
            assign ne = cell_entry[i+1];
        end

        sis_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (occ),
            .prev_place (pp),
            .prev_entry (pe),
            .next_entry (ne),
            .entry      (cell_entry[i]),
            .place      (cell_place[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_entry_next = rsp_entry_reg;
        rsp_vres_next  = rsp_vres_reg;
        rsp_last_next  = rsp_last_reg;
        rsp_ovf_next   = rsp_ovf_reg;

        if (rsp.ready)
            rsp_valid_next = 1'b0;

        if (cmd.ins)
            count_next = count_reg + 1'b1;
        else if (cmd.pop)
            count_next = count_reg - 1'b1;

        if (req_fire && !is_read && full)
            ovf_next = 1'b1;

        if (req_fire && is_read)
        begin
            rsp_valid_next = 1'b1;
            rsp_entry_next = empty ? '0 : cell_entry[0];
            rsp_vres_next  = !empty;
            rsp_last_next  = (count_reg == CNT_W'(1));
            rsp_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_entry_reg <= rsp_entry_next;
        rsp_vres_reg  <= rsp_vres_next;
        rsp_last_reg  <= rsp_last_next;
        rsp_ovf_reg   <= rsp_ovf_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_key   = rsp_entry_reg.key;
    assign rsp.out_tag   = rsp_entry_reg.tag;
    assign rsp.valid_res = rsp_vres_reg;
    assign rsp.last      = rsp_last_reg;
    assign rsp.overflow  = rsp_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !is_read && full) |=> (count_reg == CNT_W'(DEPTH)) && ovf_reg)
        else $error("insert into full store not dropped");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_read && empty) |=> rsp_valid_reg && !rsp_vres_reg && !rsp_last_reg)
        else $error("read of empty store reported an entry");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement count");

endmodule

FILE: bench/stable_insertion_sorter_tb.sv
// Self-checking bench for the stable insertion sorter: directed and random insert/read traffic.
module stable_insertion_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_SLACK = 8;

    typedef struct packed {
        logic [sis_pkg::KEY_W-1:0] key;
        logic [sis_pkg::TAG_W-1:0] tag;
        logic                      valid_res;
        logic                      last;
        logic                      overflow;
    } pop_result_t;

    logic clk;
    logic rst_n;

    sis_req_if req_ch ();
    sis_rsp_if rsp_ch ();

    stable_insertion_sorter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state: sorted list of stored entries plus the sticky flag
    sis_pkg::entry_t sorted_entries[$];
    logic            overflow_sticky;
    pop_result_t     expected_pops[$];

    int unsigned error_count;
    int unsigned cycle_count;
    bit          send_idle_en;
    bit          recv_idle_en;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pops outstanding", cycle_count,
                     expected_pops.size());
            $display("stable_insertion_sorter regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [sis_pkg::KEY_W-1:0] rand_key();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 7);           // dense range, lots of ties
            4: return ($urandom_range(0, 3) << 16) | (r & 32'h0000_FFFF);
            default: return r;
        endcase
    endfunction

    function automatic logic [sis_pkg::TAG_W-1:0] rand_tag();
        logic [31:0] r;
        r = $urandom;
        return r[sis_pkg::TAG_W-1:0];
    endfunction

    // Apply one accepted request to the predictor.
    function automatic void apply_request(input sis_pkg::kind_t kind, input sis_pkg::entry_t e);
        int          pos;
        pop_result_t res;
        if (kind == sis_pkg::KIND_INSERT)
        begin
            if (sorted_entries.size() >= sis_pkg::SIS_DEPTH)
            begin
                overflow_sticky = 1'b1;
                return;
            end
            // new entry goes behind every stored entry of equal or lower key
            pos = sorted_entries.size();
            while (pos > 0 && sorted_entries[pos-1].key > e.key)
                pos--;
            sorted_entries.insert(pos, e);
        end
        else
        begin
            res = '0;
            res.overflow = overflow_sticky;
            if (sorted_entries.size() != 0)
            begin
                res.key       = sorted_entries[0].key;
                res.tag       = sorted_entries[0].tag;
                res.valid_res = 1'b1;
                res.last      = (sorted_entries.size() == 1);
                void'(sorted_entries.pop_front());
            end
            expected_pops.push_back(res);
        end
    endfunction

    task automatic send_beat(input sis_pkg::kind_t kind, input logic [sis_pkg::KEY_W-1:0] key,
                             input logic [sis_pkg::TAG_W-1:0] tag);
        int unsigned     gap;
        sis_pkg::entry_t e;
        gap = send_idle_en ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        req_ch.tag   <= tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        e.key = key;
        e.tag = tag;
        apply_request(kind, e);
    endtask

    task automatic insert_entry(input logic [sis_pkg::KEY_W-1:0] key,
                                input logic [sis_pkg::TAG_W-1:0] tag);
        send_beat(sis_pkg::KIND_INSERT, key, tag);
    endtask

    task automatic read_smallest();
        send_beat(sis_pkg::KIND_READ, rand_key(), rand_tag());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_pops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // response side: random backpressure
    initial
    begin : rsp_ready_drive
        int unsigned hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (recv_idle_en)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_pops
        pop_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_pops.size() == 0)
                report_mismatch("beat with no read pending", rsp_ch.out_key, '0);
            else
            begin
                want = expected_pops.pop_front();
                if (rsp_ch.out_key !== want.key)
                    report_mismatch("out_key", rsp_ch.out_key, want.key);
                if (rsp_ch.out_tag !== want.tag)
                    report_mismatch("out_tag", rsp_ch.out_tag, want.tag);
                if (rsp_ch.valid_res !== want.valid_res)
                    report_mismatch("valid_res", rsp_ch.valid_res, want.valid_res);
                if (rsp_ch.last !== want.last)
                    report_mismatch("last", rsp_ch.last, want.last);
                if (rsp_ch.overflow !== want.overflow)
                    report_mismatch("overflow", rsp_ch.overflow, want.overflow);
            end
        end
    end

    task automatic test_empty_read();
        read_smallest();
    endtask

    // extremes, ties and the single-entry case
    task automatic test_directed_order();
        insert_entry(32'hFFFF_FFFF, 16'hFFFF);
        insert_entry(32'h0000_0000, 16'h0000);
        insert_entry(32'h0001_0000, 16'h0001);
        insert_entry(32'h0001_0000, 16'h0002);
        insert_entry(32'h0000_0000, 16'hFFFF);
        insert_entry(32'h0001_0000, 16'h0003);
        insert_entry(32'h8000_0000, 16'h8000);
        insert_entry(32'hFFFF_FFFF, 16'h5555);
        repeat (9) read_smallest();
        insert_entry(32'h7FFF_FFFF, 16'hAAAA);
        read_smallest();
        read_smallest();
    endtask

    task automatic test_random_mixed(input int unsigned n_items, input bit allow_full,
                                     input int unsigned read_pct);
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
            begin
                send_idle_en = ($urandom_range(0, 3) != 0);
                recv_idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < read_pct ||
                (!allow_full && sorted_entries.size() >= sis_pkg::SIS_DEPTH - 4))
                read_smallest();
            else
                insert_entry(rand_key(), rand_tag());
        end
    endtask

    // fill a batch, then pop it all and up to two reads past empty
    task automatic test_sort_batches(input int unsigned n_batches);
        int unsigned batch;
        while (sorted_entries.size() != 0)
            read_smallest();
        for (int unsigned b = 0; b < n_batches; b++)
        begin
            send_idle_en = ($urandom_range(0, 2) != 0);
            recv_idle_en = ($urandom_range(0, 2) != 0);
            batch = (b % 10 == 5) ? sis_pkg::SIS_DEPTH : $urandom_range(1, 12);
            repeat (batch) insert_entry(rand_key(), rand_tag());
            repeat (batch + $urandom_range(0, 2)) read_smallest();
            if (b == n_batches / 2)
                wait_drained();
        end
    endtask

    task automatic test_overflow();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        while (sorted_entries.size() < sis_pkg::SIS_DEPTH)
            insert_entry(rand_key(), rand_tag());
        repeat ($urandom_range(1, 5)) insert_entry(rand_key(), rand_tag());
        repeat (sis_pkg::SIS_DEPTH + 1) read_smallest();
        test_random_mixed(300, 1'b1, 40);
    endtask

    initial
    begin
        error_count     = 0;
        cycle_count     = 0;
        overflow_sticky = 1'b0;
        send_idle_en    = 1'b0;
        recv_idle_en    = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = sis_pkg::KIND_INSERT;
        req_ch.key      = '0;
        req_ch.tag      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_read();
        test_directed_order();
        test_random_mixed(400, 1'b0, 45);
        test_sort_batches(30);
        test_overflow();

        wait_drained();
        if (expected_pops.size() != 0)
            report_mismatch("reads never answered", expected_pops.size(), 0);
        if (error_count == 0)
            $display("stable_insertion_sorter regression: pass");
        else
            $display("stable_insertion_sorter regression: fail");
        $finish;
    end

endmodule
